@@ rtl/core/tll_pkg.sv @@
// Package for the tiny language lexer: token kinds, scanner modes,
// character codes and the keyword and symbol lookup functions.
// No dependencies.
package tll_pkg;

  localparam int KIND_W  = 5;
  localparam int LINE_W  = 16;
  localparam int LEN_W   = 16;
  localparam int CH_W    = 8;
  localparam int KW_KEEP = 6;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  // Character codes
  localparam logic [CH_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [CH_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CH_W-1:0] CH_EQUAL   = 8'h3D;
  localparam logic [CH_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [CH_W-1:0] CH_LESS    = 8'h3C;
  localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CH_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CH_W-1:0] CH_DIG_0   = 8'h30;
  localparam logic [CH_W-1:0] CH_DIG_9   = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z    = 8'h7A;

  // Keyword spellings, first character in the top byte
  localparam logic [15:0] KW_IF     = "if";
  localparam logic [23:0] KW_END    = "end";
  localparam logic [31:0] KW_THEN   = "then";
  localparam logic [31:0] KW_ELSE   = "else";
  localparam logic [31:0] KW_READ   = "read";
  localparam logic [39:0] KW_UNTIL  = "until";
  localparam logic [39:0] KW_WRITE  = "write";
  localparam logic [47:0] KW_REPEAT = "repeat";

  typedef enum logic [KIND_W-1:0] {
    KIND_SEMI   = 5'd0,
    KIND_IF     = 5'd1,
    KIND_THEN   = 5'd2,
    KIND_ELSE   = 5'd3,
    KIND_END    = 5'd4,
    KIND_REPEAT = 5'd5,
    KIND_UNTIL  = 5'd6,
    KIND_ID     = 5'd7,
    KIND_ASSIGN = 5'd8,
    KIND_READ   = 5'd9,
    KIND_WRITE  = 5'd10,
    KIND_LT     = 5'd11,
    KIND_EQ     = 5'd12,
    KIND_PLUS   = 5'd13,
    KIND_MINUS  = 5'd14,
    KIND_STAR   = 5'd15,
    KIND_SLASH  = 5'd16,
    KIND_LPAREN = 5'd17,
    KIND_RPAREN = 5'd18,
    KIND_NUM    = 5'd19,
    KIND_ERR    = 5'd20,
    KIND_EOF    = 5'd21
  } tok_kind_t;

  typedef enum logic [4:0] {
    MODE_START   = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_NUM     = 5'b00100,
    MODE_ID      = 5'b01000,
    MODE_ASSIGN  = 5'b10000
  } scan_mode_t;

  // Token pushes from the scanner into the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } tok_push_t;

  typedef logic [KW_KEEP-1:0][CH_W-1:0] kw_buf_t;

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    is_alpha = (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    is_digit = (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

  // One-character symbols; anything else maps to the error kind
  function automatic tok_kind_t symbol_kind(input logic [CH_W-1:0] c);
    tok_kind_t k;
    case (c)
      CH_SEMI:   k = KIND_SEMI;
      CH_LESS:   k = KIND_LT;
      CH_EQUAL:  k = KIND_EQ;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_ERR;
    endcase
    return k;
  endfunction

  // Keyword match on the kept characters; words over six never match
  function automatic tok_kind_t kw_lookup(input kw_buf_t b, input logic [LEN_W-1:0] len);
    tok_kind_t k;
    k = KIND_ID;
    case (len)
      16'd2: begin
        if ({b[0], b[1]} == KW_IF) k = KIND_IF;
      end
      16'd3: begin
        if ({b[0], b[1], b[2]} == KW_END) k = KIND_END;
      end
      16'd4: begin
        if ({b[0], b[1], b[2], b[3]} == KW_THEN) k = KIND_THEN;
        if ({b[0], b[1], b[2], b[3]} == KW_ELSE) k = KIND_ELSE;
        if ({b[0], b[1], b[2], b[3]} == KW_READ) k = KIND_READ;
      end
      16'd5: begin
        if ({b[0], b[1], b[2], b[3], b[4]} == KW_UNTIL) k = KIND_UNTIL;
        if ({b[0], b[1], b[2], b[3], b[4]} == KW_WRITE) k = KIND_WRITE;
      end
      16'd6: begin
        if ({b[0], b[1], b[2], b[3], b[4], b[5]} == KW_REPEAT) k = KIND_REPEAT;
      end
      default: k = KIND_ID;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/tll_scan.sv @@
// Scanner state and token builder: one character per accepted item,
// up to two packed tokens per item. Depends on tll_pkg.
module tll_scan #(
  parameter int NUMBER_WIDTH = 32,
  parameter int OFFSET_WIDTH = 32,
  localparam int TokW = tll_pkg::KIND_W + tll_pkg::LINE_W + NUMBER_WIDTH
                        + OFFSET_WIDTH + tll_pkg::LEN_W + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [tll_pkg::CH_W-1:0]  ch,
  input  logic                      end_of_text,
  output tll_pkg::tok_push_t        push,
  output logic [TokW-1:0]           tok0,
  output logic [TokW-1:0]           tok1
);
  import tll_pkg::*;

  localparam int AccW = NUMBER_WIDTH + 4;

  scan_mode_t                 mode_r, mode_nxt;
  kw_buf_t                    kw_buf_r, kw_buf_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [NUMBER_WIDTH-1:0]    acc_r, acc_nxt;
  logic [LINE_W-1:0]          line_r, line_nxt;
  logic [OFFSET_WIDTH-1:0]    off_r, off_nxt;
  logic [OFFSET_WIDTH-1:0]    st_off_r, st_off_nxt;
  logic [LINE_W-1:0]          st_line_r, st_line_nxt;

  logic                       c_alpha, c_digit, c_blank, s_v, p_v;
  tok_kind_t                  sym, p_kind, x_kind, y_kind;
  logic [LEN_W-1:0]           p_len, x_len, y_len, len_bump;
  logic [NUMBER_WIDTH-1:0]    p_val, x_val, acc_step;
  logic [AccW-1:0]            acc_wide;
  logic                       x_v, y_v, y_eof, rescan;

  // Classify the incoming character
  assign c_alpha = is_alpha(ch);
  assign c_digit = is_digit(ch);
  assign c_blank = is_blank(ch);
  assign sym     = symbol_kind(ch);
  assign s_v     = !(ch == CH_LBRACE || ch == CH_COLON || c_alpha || c_digit || c_blank);

  // Pending token, as flushed by a breaking character or end of text
  assign p_v    = (mode_r == MODE_ID) || (mode_r == MODE_NUM) || (mode_r == MODE_ASSIGN);
  assign p_kind = (mode_r == MODE_ID) ? kw_lookup(kw_buf_r, len_r) :
                  (mode_r == MODE_NUM) ? KIND_NUM : KIND_ERR;
  assign p_len  = (mode_r == MODE_ASSIGN) ? LEN_W'(1) : len_r;
  assign p_val  = (mode_r == MODE_NUM) ? acc_r : '0;

  // Saturating decimal step: acc * 10 + digit
  assign acc_wide = (AccW'(acc_r) << 3) + (AccW'(acc_r) << 1) + AccW'(ch[3:0]);
  assign acc_step = (acc_wide[AccW-1:NUMBER_WIDTH] != '0) ? '1 : acc_wide[NUMBER_WIDTH-1:0];
  assign len_bump = (len_r != LEN_MAX) ? len_r + LEN_W'(1) : len_r;

  // Next state and emitted tokens
  always_comb begin
    mode_nxt    = mode_r;
    kw_buf_nxt  = kw_buf_r;
    len_nxt     = len_r;
    acc_nxt     = acc_r;
    line_nxt    = line_r;
    off_nxt     = off_r;
    st_off_nxt  = st_off_r;
    st_line_nxt = st_line_r;
    x_v         = 1'b0;
    x_kind      = p_kind;
    x_len       = p_len;
    x_val       = p_val;
    y_v         = 1'b0;
    y_eof       = 1'b0;
    rescan      = 1'b0;
    if (accept) begin
      if (end_of_text) begin
        x_v         = p_v;
        y_v         = 1'b1;
        y_eof       = 1'b1;
        mode_nxt    = MODE_START;
        len_nxt     = '0;
        acc_nxt     = '0;
        line_nxt    = LINE_W'(1);
        off_nxt     = '0;
        st_off_nxt  = '0;
        st_line_nxt = LINE_W'(1);
      end else begin
        case (mode_r)
          MODE_COMMENT: begin
            if (ch == CH_RBRACE) mode_nxt = MODE_START;
          end
          MODE_ASSIGN: begin
            x_v = 1'b1;
            if (ch == CH_EQUAL) begin
              x_kind   = KIND_ASSIGN;
              x_len    = LEN_W'(2);
              x_val    = '0;
              mode_nxt = MODE_START;
            end else begin
              rescan = 1'b1;
            end
          end
          MODE_ID: begin
            if (c_alpha || c_digit) begin
              if (len_r < LEN_W'(KW_KEEP)) kw_buf_nxt[len_r[2:0]] = ch;
              len_nxt = len_bump;
            end else begin
              x_v    = 1'b1;
              rescan = 1'b1;
            end
          end
          MODE_NUM: begin
            if (c_digit) begin
              acc_nxt = acc_step;
              len_nxt = len_bump;
            end else begin
              x_v    = 1'b1;
              rescan = 1'b1;
            end
          end
          default: rescan = 1'b1;
        endcase

        // Scan the character afresh from start mode
        if (rescan) begin
          mode_nxt = MODE_START;
          y_v      = s_v;
          if (ch == CH_LBRACE) begin
            mode_nxt = MODE_COMMENT;
          end else if (ch == CH_COLON || c_alpha || c_digit) begin
            st_off_nxt  = off_r;
            st_line_nxt = line_r;
            len_nxt     = LEN_W'(1);
            if (ch == CH_COLON) begin
              mode_nxt = MODE_ASSIGN;
            end else if (c_alpha) begin
              mode_nxt      = MODE_ID;
              kw_buf_nxt[0] = ch;
            end else begin
              mode_nxt = MODE_NUM;
              acc_nxt  = NUMBER_WIDTH'(ch[3:0]);
            end
          end
        end

        // Advance line and offset after the character
        if (ch == CH_NEWLINE && line_r != LINE_MAX) line_nxt = line_r + LINE_W'(1);
        off_nxt = off_r + OFFSET_WIDTH'(1);
      end
    end
  end

  // Compact the two candidates into slot order
  assign y_kind = y_eof ? KIND_EOF : sym;
  assign y_len  = y_eof ? '0 : LEN_W'(1);

  assign push.push0 = x_v || y_v;
  assign push.push1 = x_v && y_v;
  assign tok1 = {y_kind, line_r, {NUMBER_WIDTH{1'b0}}, off_r, y_len, 1'b1};
  assign tok0 = x_v ? {x_kind, st_line_r, x_val, st_off_r, x_len, !y_v} : tok1;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_START;
      len_r     <= '0;
      acc_r     <= '0;
      line_r    <= LINE_W'(1);
      off_r     <= '0;
      st_off_r  <= '0;
      st_line_r <= LINE_W'(1);
    end else begin
      mode_r    <= mode_nxt;
      len_r     <= len_nxt;
      acc_r     <= acc_nxt;
      line_r    <= line_nxt;
      off_r     <= off_nxt;
      st_off_r  <= st_off_nxt;
      st_line_r <= st_line_nxt;
    end
  end

  // Keyword characters, only read once written for the current word
  always_ff @(posedge clk) begin
    kw_buf_r <= kw_buf_nxt;
  end

`ifndef SYNTHESIS
  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> !push.push0)
    else $error("token pushed without an accepted item");
  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_text |=> mode_r == MODE_START && line_r == LINE_W'(1) && off_r == '0)
    else $error("end of text did not return the scanner to its reset state");
  a_comment_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !end_of_text && mode_r == MODE_COMMENT |-> !push.push0)
    else $error("token emitted inside a comment");
`endif

endmodule

@@ rtl/core/tll_outq.sv @@
// Result queue: four token entries, up to two pushed per cycle, one
// popped per cycle while out_ready is high. Depends on tll_pkg for the push struct.
module tll_outq #(
  parameter int DATA_W = 102
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tll_pkg::tok_push_t push,
  input  logic [DATA_W-1:0]  d0,
  input  logic [DATA_W-1:0]  d1,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_data
);
  import tll_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] mem_r [Depth];
  logic [PtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [1:0]        n_push;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push.push0} + {1'b0, push.push1};
  assign count_nxt = count_r + CntW'(n_push) - CntW'(pop);
  assign wr_nxt    = wr_r + PtrW'(n_push);
  assign rd_nxt    = rd_r + PtrW'(pop);

  // Room for a full item's worth of tokens
  assign space     = (count_r <= CntW'(Depth - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Write entries in push order
  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wr_r] <= d0;
    if (push.push1) mem_r[wr_r + PtrW'(1)] <= d1;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("result queue fill level out of range");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> count_r <= CntW'(Depth - 2))
    else $error("token pushed without room for two");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 && count_r == '0 |=> out_valid)
    else $error("pushed token did not appear at the output");
`endif

endmodule

@@ rtl/core/tiny_language_lexer.sv @@
// Top level of the tiny language lexer: scanner plus result queue.
// Depends on tll_pkg, tll_scan and tll_outq.
//
//  channel | ports                                    | moves
//  --------+------------------------------------------+-----------------------------
//  in      | in_valid, in_ready, in_ch, in_end_of_text | one source character item
//  out     | out_valid, out_ready, out_token_kind, ... | one token item
//
// One character is taken per cycle while in_ready is high; its tokens are queued.
// An item yields zero, one or two tokens; the four-entry result queue takes
// an item only while two entries are free, so a second token stalls input
// only when the output side is also stalled or the queue is filling.
// rst_n is synchronous: the scanner returns to start mode, line one, offset
// zero, and the queue empties.
module tiny_language_lexer #(
  parameter int NUMBER_WIDTH = 32,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tll_pkg::CH_W-1:0]     in_ch,
  input  logic                         in_end_of_text,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tll_pkg::KIND_W-1:0]   out_token_kind,
  output logic [tll_pkg::LINE_W-1:0]   out_line_number,
  output logic [NUMBER_WIDTH-1:0]      out_number_value,
  output logic [OFFSET_WIDTH-1:0]      out_text_start,
  output logic [tll_pkg::LEN_W-1:0]    out_text_length,
  output logic                         out_is_last
);
  import tll_pkg::*;

  localparam int TokW = KIND_W + LINE_W + NUMBER_WIDTH + OFFSET_WIDTH + LEN_W + 1;

  tok_push_t        push;
  logic [TokW-1:0]  tok0, tok1, q_data;
  logic             accept;

  assign accept = in_valid && in_ready;

  // Scan characters into tokens
  tll_scan #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .ch          (in_ch),
    .end_of_text (in_end_of_text),
    .push        (push),
    .tok0        (tok0),
    .tok1        (tok1)
  );

  // Hold tokens until taken
  tll_outq #(
    .DATA_W (TokW)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .d0        (tok0),
    .d1        (tok1),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  // Unpack the head token
  assign {out_token_kind, out_line_number, out_number_value,
          out_text_start, out_text_length, out_is_last} = q_data;

endmodule

@@ tb/tiny_language_lexer_tb.sv @@
// Self-checking testbench for tiny_language_lexer: feeds source characters,
// predicts every token in step with the lexer and checks each one field by field.
// Depends on tll_pkg and the lexer RTL.
module tiny_language_lexer_tb;
  import tll_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 410;
  localparam int SETTLE       = 16;

  typedef struct {
    tok_kind_t   kind;
    logic [15:0] line;
    logic [31:0] value;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         drain;
  } src_item_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch          = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_line_number;
  logic [31:0] out_number_value;
  logic [31:0] out_text_start;
  logic [15:0] out_text_length;
  logic        out_is_last;

  src_item_t source_chars[$];
  token_t    tokens_due[$];
  token_t    step_toks[$];

  int errors;
  int chars_sent;
  int total_chars;
  int tokens_checked;
  int eot_marks;
  int double_steps;
  int cycles;

  // Lexer state as the testbench tracks it
  scan_mode_t  sc_mode;
  logic [7:0]  word_buf [6];
  logic [15:0] tok_len;
  logic [15:0] line_cnt;
  logic [15:0] tok_line;
  logic [31:0] num_acc;
  logic [31:0] offset;
  logic [31:0] tok_offset;

  string     kw_words [8] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
  tok_kind_t kw_kinds [8] = '{KIND_IF, KIND_THEN, KIND_ELSE, KIND_END,
                              KIND_REPEAT, KIND_UNTIL, KIND_READ, KIND_WRITE};
  string     sym_chars = ";<=+-*/()";

  tiny_language_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_number_value (out_number_value),
    .out_text_start   (out_text_start),
    .out_text_length  (out_text_length),
    .out_is_last      (out_is_last)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_decimal(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic tok_kind_t symbol_of(logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_SEMI:   k = KIND_SEMI;
      CH_LESS:   k = KIND_LT;
      CH_EQUAL:  k = KIND_EQ;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_ERR;
    endcase
    return k;
  endfunction

  function void lexer_clear();
    sc_mode    = MODE_START;
    foreach (word_buf[i]) word_buf[i] = 8'h00;
    tok_len    = '0;
    num_acc    = '0;
    line_cnt   = 16'd1;
    offset     = '0;
    tok_offset = '0;
    tok_line   = 16'd1;
  endfunction

  // At most two tokens come out of one character
  function void emit_tok(tok_kind_t k, logic [15:0] ln, logic [31:0] v,
                         logic [31:0] s, logic [15:0] l);
    token_t t;
    t = '{kind: k, line: ln, value: v, start: s, len: l, last: 1'b0};
    if (step_toks.size() < 2) step_toks.push_back(t);
  endfunction

  function void open_token(scan_mode_t m);
    sc_mode    = m;
    tok_offset = offset;
    tok_line   = line_cnt;
    tok_len    = 16'd1;
  endfunction

  // Keyword only when the length matches exactly; longer words stay identifiers
  function tok_kind_t word_kind();
    tok_kind_t k;
    bit        same;
    k = KIND_ID;
    for (int i = 0; i < 8; i++) begin
      if (tok_len == kw_words[i].len()) begin
        same = 1'b1;
        for (int j = 0; j < kw_words[i].len(); j++)
          if (word_buf[j] != kw_words[i][j]) same = 1'b0;
        if (same) k = kw_kinds[i];
      end
    end
    return k;
  endfunction

  function void close_pending();
    case (sc_mode)
      MODE_ID:     emit_tok(word_kind(), tok_line, '0, tok_offset, tok_len);
      MODE_NUM:    emit_tok(KIND_NUM, tok_line, num_acc, tok_offset, tok_len);
      MODE_ASSIGN: emit_tok(KIND_ERR, tok_line, '0, tok_offset, 16'd1);
      default: ;
    endcase
    sc_mode = MODE_START;
  endfunction

  function void scan_fresh(logic [7:0] c);
    sc_mode = MODE_START;
    if (c == CH_LBRACE) begin
      sc_mode = MODE_COMMENT;
    end else if (c == CH_COLON) begin
      open_token(MODE_ASSIGN);
    end else if (is_letter(c)) begin
      open_token(MODE_ID);
      word_buf[0] = c;
    end else if (is_decimal(c)) begin
      open_token(MODE_NUM);
      num_acc = 32'(c - CH_DIG_0);
    end else if (c != CH_SPACE && c != CH_TAB && c != CH_NEWLINE) begin
      emit_tok(symbol_of(c), line_cnt, '0, offset, 16'd1);
    end
  endfunction

  function void bump_len();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  // Advance the tracked lexer by one character and queue the tokens it gives
  function void lex_char(logic [7:0] c, logic eot);
    logic [36:0] grown;
    token_t      t;
    step_toks.delete();
    if (eot) begin
      close_pending();
      emit_tok(KIND_EOF, line_cnt, '0, offset, 16'd0);
      lexer_clear();
      eot_marks++;
    end else begin
      case (sc_mode)
        MODE_COMMENT: begin
          if (c == CH_RBRACE) sc_mode = MODE_START;
        end
        MODE_ASSIGN: begin
          if (c == CH_EQUAL) begin
            emit_tok(KIND_ASSIGN, tok_line, '0, tok_offset, 16'd2);
            sc_mode = MODE_START;
          end else begin
            close_pending();
            scan_fresh(c);
          end
        end
        MODE_ID: begin
          if (is_letter(c) || is_decimal(c)) begin
            if (tok_len < 6) word_buf[tok_len] = c;
            bump_len();
          end else begin
            close_pending();
            scan_fresh(c);
          end
        end
        MODE_NUM: begin
          if (is_decimal(c)) begin
            grown = {5'b0, num_acc} * 37'd10 + 37'(c - CH_DIG_0);
            num_acc = (grown > 37'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            bump_len();
          end else begin
            close_pending();
            scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
      if (c == CH_NEWLINE && line_cnt != 16'hFFFF) line_cnt++;
      offset++;
    end
    if (step_toks.size() == 2) double_steps++;
    foreach (step_toks[i]) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      tokens_due.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(logic [7:0] c, logic eot, bit drain = 1'b0);
    source_chars.push_back('{ch: c, eot: eot, drain: drain});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NEWLINE;
    endcase
  endfunction

  // Mostly well-formed program text with random content, some noise mixed in
  task automatic add_random_text(int count);
    int         stop;
    int         pick;
    int         n;
    logic [7:0] c;
    stop = source_chars.size() + count;
    while (source_chars.size() < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        add_text(kw_words[$urandom_range(0, 7)]);
        // keyword with a tail is a plain identifier
        if ($urandom_range(0, 4) == 0) add_item(rand_letter(), 1'b0);
      end else if (pick < 30) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        add_item(rand_letter(), 1'b0);
        for (int i = 1; i < n; i++)
          add_item($urandom_range(0, 2) ? rand_letter() : rand_digit(), 1'b0);
      end else if (pick < 45) begin
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add_item(rand_digit(), 1'b0);
      end else if (pick < 60) begin
        add_item(sym_chars[$urandom_range(0, 8)], 1'b0);
      end else if (pick < 66) begin
        add_text(":=");
      end else if (pick < 70) begin
        add_item(CH_LBRACE, 1'b0);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          c = ($urandom_range(0, 4) == 0) ? CH_NEWLINE : 8'($urandom_range(8'h20, 8'h7E));
          add_item((c == CH_RBRACE) ? CH_LBRACE : c, 1'b0);
        end
        // now and then leave the comment open up to end of text
        if ($urandom_range(0, 4) == 0) add_item(8'($urandom_range(0, 255)), 1'b1);
        else add_item(CH_RBRACE, 1'b0);
      end else if (pick < 74) begin
        add_item(CH_COLON, 1'b0);
      end else if (pick < 80) begin
        add_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 84) begin
        add_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        add_item(rand_blank(), 1'b0);
      end
      // leave tokens adjacent some of the time so one character closes a token and starts the next
      if ($urandom_range(0, 9) < 6) add_item(rand_blank(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int run_phase();
    if (total_chars == 0) return 2;
    return (chars_sent * 3) / total_chars;
  endfunction

  function automatic int sender_idle_pct();
    case (run_phase())
      0:       return 17;
      1:       return 59;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (run_phase())
      0:       return 59;
      1:       return 17;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH token %0d %s: got %0d, expected %0d", tokens_checked, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------- clock, reset

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out with %0d characters left and %0d tokens due",
               source_chars.size(), tokens_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive
    bit take;
    src_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) chars_sent++;
      take = source_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct();
      // hold a draining item until every earlier token has come out
      if (take && source_chars[0].drain && (in_valid || tokens_due.size() != 0 || out_valid))
        take = 1'b0;
      if (take) begin
        nxt = source_chars.pop_front();
        in_ch          <= nxt.ch;
        in_end_of_text <= nxt.eot;
      end
      in_valid <= take;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("arrived with none due, kind", 32'(out_token_kind), '0);
        end else begin
          want = tokens_due.pop_front();
          if (out_token_kind != want.kind)
            report_mismatch("kind", 32'(out_token_kind), 32'(want.kind));
          if (out_line_number != want.line)
            report_mismatch("line", 32'(out_line_number), 32'(want.line));
          if (out_number_value != want.value)
            report_mismatch("value", out_number_value, want.value);
          if (out_text_start != want.start)
            report_mismatch("start", out_text_start, want.start);
          if (out_text_length != want.len)
            report_mismatch("length", 32'(out_text_length), 32'(want.len));
          if (out_is_last != want.last)
            report_mismatch("last flag", 32'(out_is_last), 32'(want.last));
        end
        tokens_checked++;
      end
      if (in_valid && in_ready) lex_char(in_ch, in_end_of_text);
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    lexer_clear();
    // keyword, a tab, comment over a line break, assignment, saturating number,
    // token closed by a symbol, lone colon before an unknown byte, colon at end
    add_text("if\t{a\n}x:=4294967299+:");
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(CH_COLON, 1'b0);
    add_item(8'hFF, 1'b1);
    add_item(CH_SEMI, 1'b0, 1'b1);
    add_random_text(RANDOM_ITEMS / 2);
    add_item(CH_LPAREN, 1'b0, 1'b1);
    add_random_text(RANDOM_ITEMS / 2);
    add_item(8'($urandom_range(0, 255)), 1'b1);
    total_chars = source_chars.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (source_chars.size() != 0 || in_valid || tokens_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d characters with %0d end-of-text marks; checked %0d tokens.",
             chars_sent, eot_marks, tokens_checked);
    $display("%0d characters closed one token and opened another in the same step.",
             double_steps);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
